// ===== rtl/oile_pkg.sv =====
// Shared constants and types for the ordered integer list engine.
`default_nettype none

package oile_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int ACT_W        = 3;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = 7;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_HEAD   = 3'd0,
        ACT_TAIL   = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_QUERY  = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

endpackage

`default_nettype wire

// ===== rtl/oile_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none

module oile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ordered_int_list_engine_unit.sv =====
// Top level: ordered list of signed 32-bit integers kept in a circular RAM.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+--------------------------------------
//  s_      | in  | s_tvalid / s_tready    | s_tuser[2:0] action, s_tdata value
//  m_      | out | m_tvalid / m_tready    | m_tdata found, rejected, count[6:0]
//
//  Insert at head or tail, clear and unused actions: no search, the result is registered on accept.
//  Query: search from the head, one RAM read per cycle.
//  Remove: search from the head, then one entry moved per cycle on the RAM
//  read/write port pair to close the gap.
//  Reset clears state, length, head pointer, the pending-read flag and output valid;
//  RAM contents are never cleared. A result waits in the output register; the next beat is taken once it is taken.
`default_nettype none

module ordered_int_list_engine_unit
    import oile_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  wire logic [ACT_W-1:0]     s_tuser,  // [2:0] action
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata   // [0] found, [1] rejected, [8:2] count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_rd, n_rd;
    logic [LEN_W-1:0]   r_wr, n_wr;
    logic [LEN_W-1:0]   r_pidx, n_pidx;
    logic               r_pend, n_pend;
    logic               r_is_rem, n_is_rem;
    logic [VAL_W-1:0]   r_val, n_val;
    logic               r_mvalid, n_mvalid;
    logic               r_found, n_found;
    logic               r_rej, n_rej;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [VAL_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [VAL_W-1:0]   ram_rdata;

    logic               acc;
    logic               set_res;
    logic               match;
    logic               full;
    logic [LEN_W+CNT_W-1:0] cnt_ext;
    t_action            act;

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                              input logic [LEN_W-1:0] x);
        logic [LEN_W:0] s;
        s = (LEN_W+1)'(hd) + (LEN_W+1)'(x);
        if (s >= (LEN_W+1)'(CAPACITY)) begin
            s = s - (LEN_W+1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

    oile_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_tready = (r_state == S_IDLE) && (!r_mvalid || m_tready);
    assign acc      = s_tvalid && s_tready;
    assign act      = t_action'(s_tuser);
    assign full     = (r_len >= LEN_W'(CAPACITY));
    assign match    = r_pend && (ram_rdata == r_val);
    assign ram_raddr = phys(r_head, r_rd);
    assign cnt_ext  = (LEN_W+CNT_W)'(n_len);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_len    = r_len;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_pidx   = r_pidx;
        n_pend   = 1'b0;
        n_is_rem = r_is_rem;
        n_val    = r_val;
        n_mvalid = r_mvalid && !m_tready;
        n_found  = r_found;
        n_rej    = r_rej;
        n_cnt    = r_cnt;
        set_res  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = phys(r_head, r_wr);
        ram_wdata = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_found = 1'b0;
                    n_rej   = 1'b0;
                    unique case (act)
                        ACT_HEAD: begin
                            set_res = 1'b1;
                            if (full) begin
                                n_rej = 1'b1;
                            end else begin
                                n_head    = (r_head == '0) ? IDX_W'(CAPACITY - 1)
                                                           : r_head - 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = n_head;
                                ram_wdata = s_tdata;
                                n_len     = r_len + 1'b1;
                            end
                        end
                        ACT_TAIL: begin
                            set_res = 1'b1;
                            if (full) begin
                                n_rej = 1'b1;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = phys(r_head, r_len);
                                ram_wdata = s_tdata;
                                n_len     = r_len + 1'b1;
                            end
                        end
                        ACT_REMOVE, ACT_QUERY: begin
                            n_state  = S_SEARCH;
                            n_is_rem = (act == ACT_REMOVE);
                            n_val    = s_tdata;
                            n_rd     = '0;
                        end
                        ACT_CLEAR: begin
                            set_res = 1'b1;
                            n_len   = '0;
                        end
                        default: begin
                            set_res = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (match) begin
                    if (r_is_rem) begin
                        n_state = S_SHIFT;
                        n_wr    = r_pidx;
                        n_rd    = r_pidx + 1'b1;
                    end else begin
                        n_state = S_IDLE;
                        set_res = 1'b1;
                        n_found = 1'b1;
                    end
                end else if (r_rd >= r_len) begin
                    n_state = S_IDLE;
                    set_res = 1'b1;
                    n_found = 1'b0;
                end else begin
                    n_rd   = r_rd + 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_rd;
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    ram_we = 1'b1;
                    n_wr   = r_wr + 1'b1;
                end
                if (r_rd >= r_len) begin
                    n_state = S_IDLE;
                    n_len   = r_len - 1'b1;
                    set_res = 1'b1;
                    n_found = 1'b1;
                end else begin
                    n_rd   = r_rd + 1'b1;
                    n_pend = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (set_res) begin
            n_mvalid = 1'b1;
            n_cnt    = cnt_ext[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_len    <= '0;
            r_pend   <= 1'b0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_len    <= n_len;
            r_pend   <= n_pend;
            r_mvalid <= n_mvalid;
        end
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_pidx   <= n_pidx;
        r_is_rem <= n_is_rem;
        r_val    <= n_val;
        r_found  <= n_found;
        r_rej    <= n_rej;
        r_cnt    <= n_cnt;
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = {(M_TDATA_W - CNT_W - 2)'(0), r_cnt, r_rej, r_found};

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_len == $past(r_len) || r_len == $past(r_len) + 1'b1 ||
                            r_len == $past(r_len) - 1'b1 || r_len == '0))
        else $error("list length jumped");

    a_no_write_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEARCH |-> !ram_we)
        else $error("RAM written during search");

    a_remove_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_rd >= r_len) |=> (m_tvalid && m_tdata[0]))
        else $error("remove finished without a found result");

endmodule

`default_nettype wire

// ===== verif/ordered_int_list_engine_unit_test.sv =====
// Self-checking stream testbench for the ordered integer list engine, with its own list predictor.
module ordered_int_list_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import oile_pkg::*;

    localparam int CAP          = DEF_CAPACITY;
    localparam int STALL_LONG   = 300;
    localparam int DRAIN_CYCLES = 2 * CAP + 20;
    localparam int WATCHDOG_MAX = 20000;
    localparam int POOL_N       = 16;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_MID = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;
    } t_list_cmd;

    typedef struct packed {
        logic             found;
        logic             rejected;
        logic [CNT_W-1:0] count;
    } t_list_reply;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // [31:0] value
    logic [ACT_W-1:0]     s_tuser  = '0;  // [2:0] action
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // [0] found, [1] rejected, [8:2] count

    t_list_cmd        cmds_pending[$];
    t_list_reply      replies_due[$];
    logic [VAL_W-1:0] held_vals[$];
    logic [VAL_W-1:0] value_pool[POOL_N];

    int send_gap_pct  = 0;
    int take_gap_pct  = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int err_cnt       = 0;
    bit in_beat       = 1'b0;

    ordered_int_list_engine_unit #(.CAPACITY(CAP)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // list behavior: apply one command, return the reply it produces
    function automatic t_list_reply list_apply(input logic [ACT_W-1:0] act,
                                               input logic [VAL_W-1:0] v);
        t_list_reply r;
        int          hit;
        r   = '0;
        hit = -1;
        foreach (held_vals[i]) begin
            if (hit < 0 && held_vals[i] == v) hit = i;
        end
        case (act)
            ACT_HEAD, ACT_TAIL: begin
                if (held_vals.size() >= CAP) r.rejected = 1'b1;
                else if (act == ACT_HEAD) held_vals.push_front(v);
                else held_vals.push_back(v);
            end
            ACT_REMOVE: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    held_vals.delete(hit);
                end
            end
            ACT_QUERY: r.found = (hit >= 0);
            ACT_CLEAR: held_vals.delete();
            default: ;
        endcase
        r.count = CNT_W'(held_vals.size());
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(99) < 70) return value_pool[$urandom_range(POOL_N - 1)];
        return $urandom;
    endfunction

    task automatic queue_cmd(input logic [ACT_W-1:0] a, input logic [VAL_W-1:0] v);
        t_list_cmd c;
        c.act = a;
        c.val = v;
        cmds_pending.push_back(c);
    endtask

    task automatic queue_fill(input int n);
        repeat (n) queue_cmd($urandom_range(1) ? ACT_HEAD : ACT_TAIL, pick_value());
    endtask

    task automatic queue_random(input int n);
        int               k;
        int               w;
        int               grow;
        logic [ACT_W-1:0] a;
        k = 0;
        while (k < n) begin
            if ($urandom_range(99) < 6) begin
                // run the list up to full and beyond
                queue_fill(CAP + 4);
                k += CAP + 4;
            end else begin
                grow = $urandom_range(1);
                repeat (40) begin
                    w = $urandom_range(99);
                    if (w < 2) a = ACT_CLEAR;
                    else if (w < 5) a = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
                    else if (w < (grow ? 55 : 25)) a = $urandom_range(1) ? ACT_HEAD : ACT_TAIL;
                    else if (w < (grow ? 75 : 70)) a = ACT_REMOVE;
                    else a = ACT_QUERY;
                    queue_cmd(a, pick_value());
                end
                k += 40;
            end
        end
    endtask

    task automatic drain_all();
        while (cmds_pending.size() != 0 || s_tvalid || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // sender
    always @(negedge i_clk) begin : sender
        t_list_cmd c;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_beat) begin
            if (cmds_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                c = cmds_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= c.act;
                s_tdata  <= c.val;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with its own long hold-off counter
    always @(negedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen  = hold_requests;
            stall_left = STALL_LONG;
        end
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin : monitor
        t_list_reply want;
        in_beat = 1'b0;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                in_beat = 1'b1;
                replies_due.push_back(list_apply(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, 0);
                end else begin
                    want = replies_due.pop_front();
                    if (m_tdata[0] !== want.found)
                        report_mismatch("found", m_tdata[0], want.found);
                    if (m_tdata[1] !== want.rejected)
                        report_mismatch("rejected", m_tdata[1], want.rejected);
                    if (m_tdata[2 +: CNT_W] !== want.count)
                        report_mismatch("count", m_tdata[2 +: CNT_W], want.count);
                    if (m_tdata[M_TDATA_W-1:CNT_W+2] !== '0)
                        report_mismatch("pad bits", m_tdata[M_TDATA_W-1:CNT_W+2], 0);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'h0000_0001;
        value_pool[2] = 32'hFFFF_FFFF;
        value_pool[3] = 32'h8000_0000;
        value_pool[4] = 32'h7FFF_FFFF;
        value_pool[5] = 32'h5555_5555;
        value_pool[6] = 32'hAAAA_AAAA;
        for (int i = 7; i < POOL_N; i++) value_pool[i] = $urandom;

        send_gap_pct = 8;
        take_gap_pct = 61;

        // empty-list cases
        queue_cmd(ACT_QUERY, 32'h0000_0000);
        queue_cmd(ACT_REMOVE, 32'h0000_0000);
        queue_cmd(ACT_CLEAR, 32'h0000_0000);
        // extremes, duplicates, hits at head, tail and middle
        queue_cmd(ACT_HEAD, 32'h8000_0000);
        queue_cmd(ACT_TAIL, 32'h7FFF_FFFF);
        queue_cmd(ACT_HEAD, 32'h0000_0000);
        queue_cmd(ACT_TAIL, 32'hFFFF_FFFF);
        queue_cmd(ACT_HEAD, 32'hFFFF_FFFF);
        queue_cmd(ACT_QUERY, 32'h7FFF_FFFF);
        queue_cmd(ACT_QUERY, 32'h8000_0000);
        queue_cmd(ACT_QUERY, 32'h0000_0001);
        queue_cmd(ACT_REMOVE, 32'hFFFF_FFFF);
        queue_cmd(ACT_QUERY, 32'hFFFF_FFFF);
        queue_cmd(ACT_REMOVE, 32'h7FFF_FFFF);
        queue_cmd(ACT_REMOVE, 32'h1234_5678);
        queue_cmd(ACT_REMOVE, 32'h0000_0000);
        // unused codes leave the list alone
        queue_cmd(ACT_SPARE_LO, 32'h8000_0000);
        queue_cmd(ACT_SPARE_MID, 32'hFFFF_FFFF);
        queue_cmd(ACT_SPARE_HI, 32'h0000_0000);
        queue_cmd(ACT_CLEAR, 32'hFFFF_FFFF);
        queue_cmd(ACT_CLEAR, 32'h0000_0000);
        queue_cmd(ACT_QUERY, 32'hFFFF_FFFF);
        // fill to full, overflow on both ends, then reopen a slot
        queue_fill(CAP);
        queue_cmd(ACT_HEAD, pick_value());
        queue_cmd(ACT_TAIL, pick_value());
        queue_cmd(ACT_QUERY, value_pool[0]);
        queue_cmd(ACT_REMOVE, cmds_pending[cmds_pending.size() - 4].val);
        queue_cmd(ACT_TAIL, 32'h7FFF_FFFF);
        queue_cmd(ACT_HEAD, 32'h8000_0000);
        queue_random(450);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        drain_all();
        send_gap_pct = 61;
        take_gap_pct = 8;
        queue_random(500);
        drain_all();

        send_gap_pct = 0;
        take_gap_pct = 0;
        queue_random(500);
        hold_requests++;
        drain_all();

        if (err_cnt == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
